FILE: design/hidp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the hid report descriptor parser
// no dependencies

package hidp_pkg;

	localparam int USAGE_DEPTH_DEF  = 64;
	localparam int GSTACK_DEPTH_DEF = 8;
	localparam int MAX_RECORDS_DEF  = 64;

	// one offset slot per report id and report kind
	localparam int KEY_COUNT = 768;
	localparam int KEY_W     = 10;

	// byte parser phases
	localparam logic [1:0] PH_PREFIX    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD   = 2'd1;
	localparam logic [1:0] PH_LONG_SIZE = 2'd2;
	localparam logic [1:0] PH_LONG_SKIP = 2'd3;

	// item types
	localparam logic [1:0] TYPE_MAIN   = 2'd0;
	localparam logic [1:0] TYPE_GLOBAL = 2'd1;
	localparam logic [1:0] TYPE_LOCAL  = 2'd2;

	localparam logic [3:0] TAG_LONG = 4'hF;

	// global tags
	localparam logic [3:0] G_PAGE     = 4'h0;
	localparam logic [3:0] G_LOG_MIN  = 4'h1;
	localparam logic [3:0] G_LOG_MAX  = 4'h2;
	localparam logic [3:0] G_PHY_MIN  = 4'h3;
	localparam logic [3:0] G_PHY_MAX  = 4'h4;
	localparam logic [3:0] G_EXPONENT = 4'h5;
	localparam logic [3:0] G_UNIT     = 4'h6;
	localparam logic [3:0] G_SIZE     = 4'h7;
	localparam logic [3:0] G_ID       = 4'h8;
	localparam logic [3:0] G_COUNT    = 4'h9;
	localparam logic [3:0] G_PUSH     = 4'hA;
	localparam logic [3:0] G_POP      = 4'hB;

	// local tags
	localparam logic [3:0] L_USAGE = 4'h0;
	localparam logic [3:0] L_MIN   = 4'h1;
	localparam logic [3:0] L_MAX   = 4'h2;

	// main tags
	localparam logic [3:0] M_INPUT   = 4'h8;
	localparam logic [3:0] M_OUTPUT  = 4'h9;
	localparam logic [3:0] M_FEATURE = 4'hB;

	localparam logic [1:0] KIND_INPUT   = 2'd0;
	localparam logic [1:0] KIND_OUTPUT  = 2'd1;
	localparam logic [1:0] KIND_FEATURE = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef struct packed {
		logic [31:0] log_min;
		logic [31:0] log_max;
		logic [31:0] phy_min;
		logic [31:0] phy_max;
		logic [7:0]  exponent;
		logic [31:0] unit;
		logic [15:0] page;
		logic [7:0]  rsize;
		logic [15:0] rcount;
		logic [7:0]  rid;
	} gstate_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] offset;
	} offs_ent_t;

	function automatic logic [2:0] payload_len(input logic [7:0] p);
		payload_len = (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
	endfunction

	function automatic logic [31:0] sign_ext(input logic [31:0] v, input logic [2:0] len);
		case (len)
			3'd0: sign_ext = 32'd0;
			3'd1: sign_ext = {{24{v[7]}}, v[7:0]};
			3'd2: sign_ext = {{16{v[15]}}, v[15:0]};
			default: sign_ext = v;
		endcase
	endfunction

endpackage

FILE: design/hidp_gstack.sv
`timescale 1ns / 1ps
// push and pop stack memory for the global item state
// depends on hidp_pkg

module hidp_gstack #(
	parameter int DEPTH = hidp_pkg::GSTACK_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  hidp_pkg::gstate_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output hidp_pkg::gstate_t rd_data
);

	hidp_pkg::gstate_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/hidp_offs.sv
`timescale 1ns / 1ps
// running bit offset memory, one entry per report id and kind, with clearing sweep
// depends on hidp_pkg

module hidp_offs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sweep,
	output logic                        swept,
	input  logic                        rd_en,
	input  logic [hidp_pkg::KEY_W-1:0]  rd_addr,
	output hidp_pkg::offs_ent_t         rd_data,
	input  logic                        wr_en,
	input  logic [hidp_pkg::KEY_W-1:0]  wr_addr,
	input  hidp_pkg::offs_ent_t         wr_data
);

	hidp_pkg::offs_ent_t mem [hidp_pkg::KEY_COUNT];
	logic [hidp_pkg::KEY_W-1:0] clr_q;

	assign swept = sweep && (clr_q == hidp_pkg::KEY_W'(hidp_pkg::KEY_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (sweep && !swept) begin
			clr_q <= clr_q + 1'b1;
		end else begin
			clr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/hid_report_descriptor_parser.sv
`timescale 1ns / 1ps
// top level of the hid report descriptor parser: byte parser, item sequencer, usage list
// depends on hidp_pkg, hidp_gstack, hidp_offs
//
// usage:
// - input channel: one descriptor byte per transfer (data_byte, last_byte) on
//   in_valid / in_stall. last_byte marks the final byte of a descriptor; after
//   it the whole parser state returns to its reset value.
// - output channel: one field record per transfer on out_valid / out_stall,
//   last_record high on the final record of a main item.
// - a byte that does not finish an item is taken in ST_IDLE. a finished global
//   or local item passes through ST_EXEC, a pop also through ST_POP. a usage
//   maximum that expands a range stays in ST_RANGE for each expanded usage
//   plus a closing step. an input, output or feature item with records passes
//   ST_EXEC and ST_OFFS, then ST_EREAD (usage memory read) and ST_EOUT (output
//   load) per emitted record. no new byte is taken until the item is done.
// - records wait in a single output register; while out_stall holds, a further
//   record of the same item waits in the sequencer and in_stall stays high.
// - at reset and after every last_byte the offset memory is swept, one entry
//   a cycle over all 768 entries, while in_stall is high.
// - the global stack and the usage list have no clearing; an entry is only
//   used after it is written.

module hid_report_descriptor_parser #(
	parameter int USAGE_DEPTH          = hidp_pkg::USAGE_DEPTH_DEF,
	parameter int GLOBAL_STACK_DEPTH   = hidp_pkg::GSTACK_DEPTH_DEF,
	parameter int MAX_RECORDS_PER_ITEM = hidp_pkg::MAX_RECORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  report_number,
	output logic [1:0]  report_kind,
	output logic [31:0] usage_code,
	output logic [15:0] bit_position,
	output logic [7:0]  bit_width,
	output logic signed [31:0] logical_low,
	output logic signed [31:0] logical_high,
	output logic signed [31:0] physical_low,
	output logic signed [31:0] physical_high,
	output logic signed [7:0]  power_of_ten,
	output logic [31:0] unit_code,
	output logic        last_record
);

	localparam int UIW = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
	localparam int UFW = $clog2(USAGE_DEPTH + 1);
	localparam int SAW = (GLOBAL_STACK_DEPTH > 1) ? $clog2(GLOBAL_STACK_DEPTH) : 1;
	localparam int SLW = $clog2(GLOBAL_STACK_DEPTH + 1);
	localparam int RCW = $clog2(MAX_RECORDS_PER_ITEM + 1);

	// sequencer states
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_EXEC  = 4'd2;
	localparam logic [3:0] ST_POP   = 4'd3;
	localparam logic [3:0] ST_RANGE = 4'd4;
	localparam logic [3:0] ST_OFFS  = 4'd5;
	localparam logic [3:0] ST_EREAD = 4'd6;
	localparam logic [3:0] ST_EOUT  = 4'd7;

	logic [3:0]  state_q;
	logic [1:0]  phase_q;
	logic [7:0]  prefix_q;
	logic [31:0] payload_q;
	logic [8:0]  remain_q;
	logic        last_q;
	hidp_pkg::gstate_t g_q;
	logic        id_seen_q;
	logic [SLW-1:0] level_q;
	logic [UFW-1:0] fill_q;
	logic [31:0] rstart_q;
	logic        rvalid_q;
	logic [16:0] rid_q;
	logic [15:0] rhi_q;
	logic [hidp_pkg::KEY_W-1:0] key_q;
	logic [1:0]  kind_q;
	logic [RCW-1:0] rec_q;
	logic [RCW-1:0] nrec_q;
	logic [15:0] pos_q;

	// usage list memory
	logic [31:0] usage_mem [USAGE_DEPTH];
	logic [31:0] u_rdata;
	logic        u_wr;
	logic [UIW-1:0] u_waddr;
	logic [31:0] u_wdata;
	logic        u_rd;
	logic [UIW-1:0] u_raddr;

	// stack and offset memory ports
	logic        s_wr, s_rd;
	logic [SAW-1:0] s_waddr, s_raddr;
	hidp_pkg::gstate_t s_rdata;
	logic        o_sweep, o_swept, o_rd, o_wr;
	hidp_pkg::offs_ent_t o_rdata, o_wdata;

	// input byte handling
	logic        in_fire;
	logic [2:0]  cur_len;
	logic [1:0]  pay_idx;
	logic [31:0] pay_merge;

	// item decode
	logic [1:0]  it_type;
	logic [3:0]  it_tag;
	logic [2:0]  it_len;
	logic [31:0] it_sext;
	logic [7:0]  it_exp;
	logic [31:0] it_usage;
	logic [1:0]  it_kind;

	// record emission
	logic        out_free;
	logic [8:0]  sel_idx;
	logic [15:0] offs_base;
	logic [23:0] offs_span;
	logic        rec_last;
	logic        fill_room;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign fill_room = (fill_q < UFW'(USAGE_DEPTH));

	assign cur_len   = hidp_pkg::payload_len(prefix_q);
	assign pay_idx   = 2'(cur_len - remain_q[2:0]);
	assign pay_merge = payload_q | ({24'd0, data_byte} << {pay_idx, 3'd0});

	assign it_type  = prefix_q[3:2];
	assign it_tag   = prefix_q[7:4];
	assign it_len   = hidp_pkg::payload_len(prefix_q);
	assign it_sext  = hidp_pkg::sign_ext(payload_q, it_len);
	// exponent nibble 8..15 means a negative power
	assign it_exp   = (it_sext >= 32'd8 && it_sext <= 32'd15) ? (it_sext[7:0] - 8'd16)
	                                                          : it_sext[7:0];
	assign it_usage = (it_len == 3'd4) ? payload_q : {g_q.page, payload_q[15:0]};

	always_comb begin
		case (it_tag)
			hidp_pkg::M_INPUT:   it_kind = hidp_pkg::KIND_INPUT;
			hidp_pkg::M_OUTPUT:  it_kind = hidp_pkg::KIND_OUTPUT;
			hidp_pkg::M_FEATURE: it_kind = hidp_pkg::KIND_FEATURE;
			default:             it_kind = hidp_pkg::KIND_NONE;
		endcase
	end

	// first use of a slot starts at 8 once any report id was seen
	assign offs_base = o_rdata.valid ? o_rdata.offset : (id_seen_q ? 16'd8 : 16'd0);
	assign offs_span = g_q.rcount * g_q.rsize;

	// element usage: entry i, else the last entry
	assign sel_idx  = (9'(rec_q) < 9'(fill_q)) ? 9'(rec_q) : (9'(fill_q) - 9'd1);
	assign rec_last = ((rec_q + 1'b1) == nrec_q);

	// memory port control
	always_comb begin
		u_wr    = 1'b0;
		u_waddr = fill_q[UIW-1:0];
		u_wdata = it_usage;
		u_rd    = (state_q == ST_EREAD);
		u_raddr = sel_idx[UIW-1:0];
		s_wr    = 1'b0;
		s_rd    = 1'b0;
		s_waddr = level_q[SAW-1:0];
		s_raddr = SAW'(level_q - 1'b1);
		o_sweep = (state_q == ST_CLEAR);
		o_rd    = 1'b0;
		o_wr    = (state_q == ST_OFFS);
		o_wdata = '{valid: 1'b1, offset: offs_base + offs_span[15:0]};
		if (state_q == ST_EXEC) begin
			case (it_type)
				hidp_pkg::TYPE_GLOBAL: begin
					s_wr = (it_tag == hidp_pkg::G_PUSH) &&
					       (level_q < SLW'(GLOBAL_STACK_DEPTH));
					s_rd = (it_tag == hidp_pkg::G_POP) && (level_q != '0);
				end
				hidp_pkg::TYPE_LOCAL: begin
					u_wr = fill_room && ((it_tag == hidp_pkg::L_USAGE) ||
					       (it_tag == hidp_pkg::L_MAX && !rvalid_q));
				end
				hidp_pkg::TYPE_MAIN: begin
					o_rd = (it_kind != hidp_pkg::KIND_NONE) && (g_q.rsize != '0) &&
					       (g_q.rcount != '0);
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_RANGE) begin
			u_wr    = (rid_q <= {1'b0, rhi_q}) && fill_room;
			u_wdata = {rstart_q[31:16], rid_q[15:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (u_wr) begin
			usage_mem[u_waddr] <= u_wdata;
		end
		if (u_rd) begin
			u_rdata <= usage_mem[u_raddr];
		end
	end

	hidp_gstack #(
		.DEPTH (GLOBAL_STACK_DEPTH),
		.AW    (SAW)
	) u_gstack (
		.clk     (clk),
		.wr_en   (s_wr),
		.wr_addr (s_waddr),
		.wr_data (g_q),
		.rd_en   (s_rd),
		.rd_addr (s_raddr),
		.rd_data (s_rdata)
	);

	hidp_offs u_offs (
		.clk     (clk),
		.arst_n  (arst_n),
		.sweep   (o_sweep),
		.swept   (o_swept),
		.rd_en   (o_rd),
		.rd_addr (10'(g_q.rid) + {1'b0, g_q.rid, 1'b0} + 10'(it_kind)),
		.rd_data (o_rdata),
		.wr_en   (o_wr),
		.wr_addr (key_q),
		.wr_data (o_wdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			phase_q   <= hidp_pkg::PH_PREFIX;
			remain_q  <= '0;
			last_q    <= 1'b0;
			id_seen_q <= 1'b0;
			level_q   <= '0;
			fill_q    <= '0;
			rvalid_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					phase_q   <= hidp_pkg::PH_PREFIX;
					remain_q  <= '0;
					last_q    <= 1'b0;
					id_seen_q <= 1'b0;
					level_q   <= '0;
					fill_q    <= '0;
					rvalid_q  <= 1'b0;
					if (o_swept) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						last_q <= last_byte;
						if (last_byte) begin
							state_q <= ST_CLEAR;
						end
						case (phase_q)
							hidp_pkg::PH_PREFIX: begin
								if (data_byte[7:4] == hidp_pkg::TAG_LONG) begin
									phase_q <= hidp_pkg::PH_LONG_SIZE;
								end else if (data_byte[1:0] == 2'd0) begin
									state_q <= ST_EXEC;
								end else begin
									remain_q <= 9'(hidp_pkg::payload_len(data_byte));
									phase_q  <= hidp_pkg::PH_PAYLOAD;
								end
							end
							hidp_pkg::PH_PAYLOAD: begin
								remain_q <= remain_q - 9'd1;
								if (remain_q == 9'd1) begin
									phase_q <= hidp_pkg::PH_PREFIX;
									state_q <= ST_EXEC;
								end
							end
							hidp_pkg::PH_LONG_SIZE: begin
								remain_q <= 9'(data_byte) + 9'd1;
								phase_q  <= hidp_pkg::PH_LONG_SKIP;
							end
							default: begin
								remain_q <= remain_q - 9'd1;
								if (remain_q == 9'd1) begin
									phase_q <= hidp_pkg::PH_PREFIX;
								end
							end
						endcase
					end
				end
				ST_EXEC: begin
					state_q <= last_q ? ST_CLEAR : ST_IDLE;
					case (it_type)
						hidp_pkg::TYPE_GLOBAL: begin
							if (it_tag == hidp_pkg::G_ID) begin
								id_seen_q <= 1'b1;
							end
							if (s_wr) begin
								level_q <= level_q + 1'b1;
							end
							if (s_rd) begin
								level_q <= level_q - 1'b1;
								state_q <= ST_POP;
							end
						end
						hidp_pkg::TYPE_LOCAL: begin
							if (u_wr) begin
								fill_q <= fill_q + 1'b1;
							end
							if (it_tag == hidp_pkg::L_MIN) begin
								rvalid_q <= 1'b1;
							end else if (it_tag == hidp_pkg::L_MAX && rvalid_q) begin
								rvalid_q <= 1'b0;
								fill_q   <= '0;
								state_q  <= ST_RANGE;
							end
						end
						hidp_pkg::TYPE_MAIN: begin
							if (o_rd) begin
								state_q <= ST_OFFS;
							end else begin
								fill_q   <= '0;
								rvalid_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_POP: begin
					state_q <= last_q ? ST_CLEAR : ST_IDLE;
				end
				ST_RANGE: begin
					if (u_wr) begin
						fill_q <= fill_q + 1'b1;
					end else begin
						state_q <= last_q ? ST_CLEAR : ST_IDLE;
					end
				end
				ST_OFFS: begin
					state_q <= ST_EREAD;
				end
				ST_EREAD: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						if (rec_last) begin
							fill_q   <= '0;
							rvalid_q <= 1'b0;
							state_q  <= last_q ? ST_CLEAR : ST_IDLE;
						end else begin
							state_q <= ST_EREAD;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLEAR: begin
				prefix_q  <= '0;
				payload_q <= '0;
				g_q       <= '0;
				rstart_q  <= '0;
			end
			ST_IDLE: begin
				if (in_fire) begin
					if (phase_q == hidp_pkg::PH_PREFIX) begin
						prefix_q  <= data_byte;
						payload_q <= '0;
					end else if (phase_q == hidp_pkg::PH_PAYLOAD) begin
						payload_q <= pay_merge;
					end
				end
			end
			ST_EXEC: begin
				if (it_type == hidp_pkg::TYPE_GLOBAL) begin
					case (it_tag)
						hidp_pkg::G_PAGE:     g_q.page     <= payload_q[15:0];
						hidp_pkg::G_LOG_MIN:  g_q.log_min  <= it_sext;
						hidp_pkg::G_LOG_MAX:  g_q.log_max  <= it_sext;
						hidp_pkg::G_PHY_MIN:  g_q.phy_min  <= it_sext;
						hidp_pkg::G_PHY_MAX:  g_q.phy_max  <= it_sext;
						hidp_pkg::G_EXPONENT: g_q.exponent <= it_exp;
						hidp_pkg::G_UNIT:     g_q.unit     <= payload_q;
						hidp_pkg::G_SIZE:     g_q.rsize    <= payload_q[7:0];
						hidp_pkg::G_ID:       g_q.rid      <= payload_q[7:0];
						hidp_pkg::G_COUNT:    g_q.rcount   <= payload_q[15:0];
						default: begin
						end
					endcase
				end else if (it_type == hidp_pkg::TYPE_LOCAL) begin
					if (it_tag == hidp_pkg::L_MIN) begin
						rstart_q <= it_usage;
					end else if (it_tag == hidp_pkg::L_MAX) begin
						rid_q <= {1'b0, rstart_q[15:0]};
						rhi_q <= it_usage[15:0];
					end
				end
				key_q  <= 10'(g_q.rid) + {1'b0, g_q.rid, 1'b0} + 10'(it_kind);
				kind_q <= it_kind;
				nrec_q <= (g_q.rcount > 16'(MAX_RECORDS_PER_ITEM)) ?
				          RCW'(MAX_RECORDS_PER_ITEM) : RCW'(g_q.rcount);
			end
			ST_POP: begin
				g_q <= s_rdata;
			end
			ST_RANGE: begin
				rid_q <= rid_q + 17'd1;
			end
			ST_OFFS: begin
				pos_q <= offs_base;
				rec_q <= '0;
			end
			ST_EOUT: begin
				if (out_free) begin
					report_number <= g_q.rid;
					report_kind   <= kind_q;
					usage_code    <= (fill_q == '0) ? {g_q.page, 16'd0} : u_rdata;
					bit_position  <= pos_q;
					bit_width     <= g_q.rsize;
					logical_low   <= g_q.log_min;
					logical_high  <= g_q.log_max;
					physical_low  <= g_q.phy_min;
					physical_high <= g_q.phy_max;
					power_of_ten  <= g_q.exponent;
					unit_code     <= g_q.unit;
					last_record   <= rec_last;
					pos_q         <= pos_q + 16'(g_q.rsize);
					rec_q         <= rec_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/hidp_checker.sv
`timescale 1ns / 1ps
// port level checks for the hid report descriptor parser, bound to the top level
// depends on hid_report_descriptor_parser

module hidp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] report_kind,
	input logic [7:0] bit_width,
	input logic       last_record
);

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(report_kind) &&
		$stable(bit_width) && $stable(last_record))
		else $error("stalled record changed");

	// after the final byte of a descriptor is taken, in_stall is high
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall)
		else $error("input taken right after last byte");

	// records never carry a zero report size
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bit_width != 8'd0)
		else $error("record with zero width");

	// only input, output and feature records
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> report_kind != 2'd3)
		else $error("record with bad kind");

endmodule

bind hid_report_descriptor_parser hidp_checker u_hidp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_byte   (last_byte),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.report_kind (report_kind),
	.bit_width   (bit_width),
	.last_record (last_record)
);
